@@ rtl/core/c8pe_pkg.sv @@
// ============================================================================
// c8pe_pkg
// Shared types and constants of the reduced interpreter core.
// ============================================================================
package c8pe_pkg;

    localparam int FontBase = 12'h050;
    localparam int FontLen = 80;

    // Request kinds carried in s_tuser.
    localparam logic [1:0] REQ_LOAD = 2'd0;
    localparam logic [1:0] REQ_STEP = 2'd1;
    localparam logic [1:0] REQ_ROW  = 2'd2;

    // Opcode groups (top nibble).
    localparam logic [3:0] OP_SYS  = 4'h0;
    localparam logic [3:0] OP_JMP  = 4'h1;
    localparam logic [3:0] OP_SETV = 4'h6;
    localparam logic [3:0] OP_ADDV = 4'h7;
    localparam logic [3:0] OP_SETI = 4'hA;
    localparam logic [3:0] OP_DRAW = 4'hD;

    // Font glyph bytes, sixteen glyphs of five rows.
    function automatic logic [7:0] font_byte(input logic [6:0] i);
        logic [7:0] g [0:79];
        g = '{8'hF0,8'h90,8'h90,8'h90,8'hF0,8'h20,8'h60,8'h20,8'h20,8'h70,
              8'hF0,8'h10,8'hF0,8'h80,8'hF0,8'hF0,8'h10,8'hF0,8'h10,8'hF0,
              8'h90,8'h90,8'hF0,8'h10,8'h10,8'hF0,8'h80,8'hF0,8'h10,8'hF0,
              8'hF0,8'h80,8'hF0,8'h90,8'hF0,8'hF0,8'h10,8'h20,8'h40,8'h40,
              8'hF0,8'h90,8'hF0,8'h90,8'hF0,8'hF0,8'h90,8'hF0,8'h10,8'hF0,
              8'hF0,8'h90,8'hF0,8'h90,8'h90,8'hE0,8'h90,8'hE0,8'h90,8'hE0,
              8'hF0,8'h80,8'h80,8'h80,8'hF0,8'hE0,8'h90,8'h90,8'h90,8'hE0,
              8'hF0,8'h80,8'hF0,8'h80,8'hF0,8'hF0,8'h80,8'hF0,8'h80,8'h80};
        font_byte = (i < 7'd80) ? g[i] : 8'h00;
    endfunction

    // Result fields handed from the sequencer to the output register.
    typedef struct packed {
        logic [11:0] pc_now;
        logic [63:0] row_pixels;
        logic        collision;
        logic        display_changed;
        logic        unhandled;
    } c8pe_result_t;

endpackage

@@ rtl/core/c8pe_ram.sv @@
// ============================================================================
// c8pe_ram
// Generic single-port RAM with a registered read.
// ============================================================================
module c8pe_ram #(
    parameter int Width = 8,
    parameter int Depth = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [0:Depth-1];

    // One access per cycle: a write also reads back the old word at that address.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

@@ rtl/core/c8pe_seq.sv @@
// ============================================================================
// c8pe_seq
// Sequencer: loads, row reads, fetch, decode, clear and row-by-row sprite draw.
// ============================================================================
module c8pe_seq (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [11:0]          start_pc,
    input  logic                 start,
    input  logic [1:0]           req_type,
    input  logic [11:0]          address,
    input  logic [7:0]           data,
    input  logic [4:0]           row_index,
    output logic                 busy,
    output logic                 done,
    output c8pe_pkg::c8pe_result_t result
);
    import c8pe_pkg::*;

    localparam logic [3:0] S_INIT  = 4'd0;  // clearing pass, font copy
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_F0    = 4'd2;  // first opcode byte arrives
    localparam logic [3:0] S_F1    = 4'd3;
    localparam logic [3:0] S_EXEC  = 4'd5;
    localparam logic [3:0] S_DMEM  = 4'd6;  // sprite byte requested
    localparam logic [3:0] S_DROW  = 4'd7;  // frame row read waits
    localparam logic [3:0] S_DWR   = 4'd8;
    localparam logic [3:0] S_CLR   = 4'd9;
    localparam logic [3:0] S_RROW  = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;
    localparam logic [3:0] S_DMEM2 = 4'd12;

    logic [3:0]  state_reg, state_next;
    logic [11:0] cnt_reg, cnt_next;
    logic [11:0] pc_reg, pc_next;
    logic [11:0] idx_reg, idx_next;
    logic [15:0] op_reg, op_next;
    logic [7:0]  v_reg [0:15];
    logic [7:0]  vx_reg, vx_next, vy_reg, vy_next;
    logic [7:0]  spr_reg, spr_next;
    logic [3:0]  row_reg, row_next;
    logic        vf_reg, vf_next;
    logic        chg_reg, chg_next, bad_reg, bad_next;
    logic [63:0] pix_reg, pix_next;
    logic        v_we;
    logic [3:0]  v_wa;
    logic [7:0]  v_wd;

    logic        m_we;
    logic [11:0] m_addr;
    logic [7:0]  m_wd, m_rd;
    logic        f_we;
    logic [4:0]  f_addr;
    logic [63:0] f_wd, f_rd;

    c8pe_ram #(.Width(8), .Depth(4096)) u_mem (
        .aclk(aclk), .we(m_we), .addr(m_addr), .wdata(m_wd), .rdata(m_rd));
    c8pe_ram #(.Width(64), .Depth(32)) u_frame (
        .aclk(aclk), .we(f_we), .addr(f_addr), .wdata(f_wd), .rdata(f_rd));

    // Sprite byte placed at x with wrap, as a 64-bit mask with x = 0 at bit 63.
    logic [63:0] spr_mask;
    logic [4:0]  draw_y;
    always_comb begin
        logic [127:0] wide;
        wide = {spr_reg, 56'd0, 64'd0} >> vx_reg[5:0];
        spr_mask = wide[127:64] | wide[63:0];
        draw_y = vy_reg[4:0] + {1'b0, row_reg};
    end

    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        pc_next = pc_reg;
        idx_next = idx_reg;
        op_next = op_reg;
        vx_next = vx_reg;
        vy_next = vy_reg;
        spr_next = spr_reg;
        row_next = row_reg;
        vf_next = vf_reg;
        chg_next = chg_reg;
        bad_next = bad_reg;
        pix_next = pix_reg;
        v_we = 1'b0;
        v_wa = op_reg[11:8];
        v_wd = op_reg[7:0];
        m_we = 1'b0;
        m_addr = pc_reg;
        m_wd = data;
        f_we = 1'b0;
        f_addr = draw_y;
        f_wd = f_rd ^ spr_mask;
        done = 1'b0;

        unique case (state_reg)
            // Zero memory and frame, copying the font in on the way.
            S_INIT: begin
                m_we = 1'b1;
                m_addr = cnt_reg;
                if (cnt_reg >= 12'(FontBase) && cnt_reg < 12'(FontBase + FontLen)) begin
                    m_wd = font_byte(7'(cnt_reg - 12'(FontBase)));
                end else begin
                    m_wd = 8'h00;
                end
                f_we = 1'b1;
                f_addr = cnt_reg[4:0];
                f_wd = '0;
                cnt_next = cnt_reg + 12'd1;
                if (cnt_reg == 12'hFFF) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                chg_next = 1'b0;
                bad_next = 1'b0;
                pix_next = '0;
                if (start) begin
                    case (req_type)
                        REQ_LOAD: begin
                            m_we = 1'b1;
                            m_addr = address;
                            state_next = S_DONE;
                        end
                        REQ_STEP: begin
                            m_addr = pc_reg;
                            state_next = S_F0;
                        end
                        REQ_ROW: begin
                            f_addr = row_index;
                            state_next = S_RROW;
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_RROW: begin
                pix_next = f_rd;
                state_next = S_DONE;
            end
            // High opcode byte is in; ask for the low one.
            S_F0: begin
                op_next[15:8] = m_rd;
                m_addr = pc_reg + 12'd1;
                state_next = S_F1;
            end
            S_F1: begin
                op_next[7:0] = m_rd;
                state_next = S_EXEC;
            end
            S_EXEC: begin
                pc_next = pc_reg + 12'd2;
                case (op_reg[15:12])
                    OP_SYS: begin
                        if (op_reg[3:0] == 4'h0) begin
                            chg_next = 1'b1;
                            cnt_next = '0;
                            state_next = S_CLR;
                        end else begin
                            bad_next = 1'b1;
                            state_next = S_DONE;
                        end
                    end
                    OP_JMP: begin
                        pc_next = op_reg[11:0];
                        state_next = S_DONE;
                    end
                    OP_SETV: begin
                        v_we = 1'b1;
                        state_next = S_DONE;
                    end
                    OP_ADDV: begin
                        v_we = 1'b1;
                        v_wd = v_reg[op_reg[11:8]] + op_reg[7:0];
                        state_next = S_DONE;
                    end
                    OP_SETI: begin
                        idx_next = op_reg[11:0];
                        state_next = S_DONE;
                    end
                    OP_DRAW: begin
                        vx_next = v_reg[op_reg[11:8]];
                        vy_next = v_reg[op_reg[7:4]];
                        vf_next = 1'b0;
                        chg_next = 1'b1;
                        row_next = '0;
                        state_next = S_DMEM;
                    end
                    default: begin
                        bad_next = 1'b1;
                        state_next = S_DONE;
                    end
                endcase
            end
            // Per sprite row: read byte, read frame row, write XOR.
            S_DMEM: begin
                if (row_reg == op_reg[3:0]) begin
                    state_next = S_DONE;
                end else begin
                    m_addr = idx_reg + 12'(row_reg);
                    state_next = S_DMEM2;
                end
            end
            S_DMEM2: begin
                spr_next = m_rd;
                state_next = S_DROW;
            end
            S_DROW: begin
                state_next = S_DWR;
            end
            S_DWR: begin
                f_we = 1'b1;
                if ((f_rd & spr_mask) != '0) begin
                    vf_next = 1'b1;
                end
                row_next = row_reg + 4'd1;
                state_next = S_DMEM;
            end
            S_CLR: begin
                f_we = 1'b1;
                f_addr = cnt_reg[4:0];
                f_wd = '0;
                cnt_next = cnt_reg + 12'd1;
                if (cnt_reg[4:0] == 5'd31) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                done = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // VF write for draw lands at the end of the draw, and at its start clears.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            cnt_reg <= '0;
            pc_reg <= start_pc;
            idx_reg <= '0;
            op_reg <= '0;
            vf_reg <= 1'b0;
            chg_reg <= 1'b0;
            bad_reg <= 1'b0;
            for (int i = 0; i < 16; i++) begin
                v_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            pc_reg <= pc_next;
            idx_reg <= idx_next;
            op_reg <= op_next;
            vf_reg <= vf_next;
            chg_reg <= chg_next;
            bad_reg <= bad_next;
            if (v_we) begin
                v_reg[v_wa] <= v_wd;
            end
            if (state_reg == S_DMEM && state_next == S_DONE) begin
                v_reg[15] <= {7'd0, vf_reg};
            end
        end
    end

    always_ff @(posedge aclk) begin
        vx_reg <= vx_next;
        vy_reg <= vy_next;
        spr_reg <= spr_next;
        row_reg <= row_next;
        pix_reg <= pix_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign result = '{pc_now: pc_reg, row_pixels: pix_reg, collision: v_reg[15][0],
                      display_changed: chg_reg, unhandled: bad_reg};
endmodule

@@ rtl/core/chip8_core_partial_execute.sv @@
// ============================================================================
// chip8_core_partial_execute
// Reduced interpreter core with byte memory, registers and a 64x32 frame.
// ============================================================================
// Channel | Dir | Transfer contents
// s_      | in  | tuser: req_type[1:0]
//         |     | tdata: address[11:0] data[19:12] row_index[24:20]
// m_      | out | tdata: pc_now[11:0] row_pixels[75:12] collision[76]
//         |     |        display_changed[77] unhandled[78]
// apb     | in  | start_pc at address 0
//
// Each request runs to completion before the next is taken; a draw reads the
// sprite byte, reads the frame row and writes the XOR back, row by row. After
// reset a clearing pass over all 4096 memory bytes zeroes memory and frame and
// copies the font; no transfer is accepted meanwhile. The output register
// holds a result until taken, and s_tready stays low then.
module chip8_core_partial_execute (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [1:0]   s_tuser,   // req_type
    input  logic [31:0]  s_tdata,   // address, data, row_index
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [79:0]  m_tdata,   // pc_now, row_pixels, collision, changed, unhandled
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [0:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import c8pe_pkg::*;

    logic [11:0]  start_pc_reg;
    logic         busy, done, accept;
    c8pe_result_t res;
    logic         mv_reg;
    logic [79:0]  md_reg;

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_pc_reg <= 12'h200;
        end else if (psel && penable && pwrite && paddr == 1'b0) begin
            start_pc_reg <= pwdata[11:0];
        end
    end
    assign pready = 1'b1;
    assign prdata = (paddr == 1'b0) ? {20'd0, start_pc_reg} : 32'd0;

    assign s_tready = !busy && !mv_reg;
    assign accept = s_tvalid && s_tready;

    c8pe_seq u_seq (
        .aclk(aclk), .aresetn(aresetn), .start_pc(start_pc_reg), .start(accept),
        .req_type(s_tuser), .address(s_tdata[11:0]), .data(s_tdata[19:12]),
        .row_index(s_tdata[24:20]), .busy(busy), .done(done), .result(res));

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= 1'b0;
        end else if (done) begin
            mv_reg <= 1'b1;
        end else if (m_tready) begin
            mv_reg <= 1'b0;
        end
    end
    always_ff @(posedge aclk) begin
        if (done) begin
            md_reg <= {1'b0, res.unhandled, res.display_changed, res.collision,
                       res.row_pixels, res.pc_now};
        end
    end
    assign m_tvalid = mv_reg;
    assign m_tdata = md_reg;
endmodule

@@ rtl/core/c8pe_checker.sv @@
// ============================================================================
// c8pe_checker
// Port-level checks of the interpreter core, bound to the top level.
// ============================================================================
module c8pe_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_tvalid,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready,
    input logic [79:0] m_tdata
);
    // Input is refused while a result is waiting.
    a_no_accept_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("input taken with result pending");
    // No result appears in the cycle after an accepted transfer.
    a_not_instant: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !m_tvalid) else $error("result too early");
    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result dropped");
endmodule

bind chip8_core_partial_execute c8pe_checker u_c8pe_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata));

@@ sim/chip8_core_partial_execute_chk.sv @@
`timescale 1ns / 100ps
// ============================================================================
// chip8_core_partial_execute_chk
// Watches both streams and the register port of the interpreter core, keeps
// its own copy of memory, registers and frame, works out the result of every
// accepted request and compares each returned result field by field.
// ============================================================================
module chip8_core_partial_execute_chk (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [1:0]  s_tuser,
    input  logic [31:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [79:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    output int          mismatch_count,
    output int          pending
);
    import c8pe_pkg::*;

    // Result fields in the order they sit in m_tdata, lowest bit last.
    typedef struct packed {
        logic        unhandled;
        logic        changed;
        logic        collision;
        logic [63:0] row_pixels;
        logic [11:0] pc_now;
    } core_result_t;

    localparam logic [7:0] GLYPHS [80] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    logic [7:0]   mem_copy [4096];
    logic [7:0]   vregs [16];
    logic [11:0]  index_copy;
    logic [11:0]  pc_copy;
    logic [63:0]  frame_copy [32];
    logic [11:0]  start_pc_copy;
    core_result_t expected_results [$];

    assign pending = expected_results.size();

    // XOR one sprite into the frame, wrapping both coordinates.
    task automatic draw_sprite(input logic [15:0] op);
        logic [7:0] x0, y0, bits;
        logic [5:0] x;
        logic [4:0] y;
        x0 = vregs[op[11:8]];
        y0 = vregs[op[7:4]];
        vregs[15] = 8'd0;
        for (int r = 0; r < op[3:0]; r++) begin
            bits = mem_copy[12'(index_copy + r)];
            y = 5'(y0 + r);
            for (int c = 0; c < 8; c++) begin
                if (bits[7 - c]) begin
                    x = 6'(x0 + c);
                    if (frame_copy[y][63 - x]) vregs[15] = 8'd1;
                    frame_copy[y][63 - x] = ~frame_copy[y][63 - x];
                end
            end
        end
    endtask

    // Apply one request to the copied state and return its result.
    task automatic execute_request(input logic [1:0] kind, input logic [31:0] d,
                                   output core_result_t res);
        logic [15:0] op;
        logic bad;
        res = '0;
        bad = 1'b0;
        case (kind)
            REQ_LOAD: mem_copy[d[11:0]] = d[19:12];
            REQ_STEP: begin
                op = {mem_copy[pc_copy], mem_copy[12'(pc_copy + 1)]};
                case (op[15:12])
                    OP_SYS: begin
                        if (op[3:0] == 4'd0) begin
                            for (int i = 0; i < 32; i++) frame_copy[i] = '0;
                            res.changed = 1'b1;
                        end else begin
                            bad = 1'b1;
                        end
                    end
                    OP_JMP:  ;
                    OP_SETV: vregs[op[11:8]] = op[7:0];
                    OP_ADDV: vregs[op[11:8]] = vregs[op[11:8]] + op[7:0];
                    OP_SETI: index_copy = op[11:0];
                    OP_DRAW: begin
                        draw_sprite(op);
                        res.changed = 1'b1;
                    end
                    default: bad = 1'b1;
                endcase
                if (op[15:12] == OP_JMP) pc_copy = op[11:0];
                else pc_copy = pc_copy + 12'd2;
                res.unhandled = bad;
            end
            REQ_ROW: res.row_pixels = frame_copy[d[24:20]];
            default: ;
        endcase
        res.pc_now = pc_copy;
        res.collision = vregs[15][0];
    endtask

    always @(posedge aclk) begin
        core_result_t got, want;
        if (!aresetn) begin
            for (int i = 0; i < 4096; i++) mem_copy[i] = 8'd0;
            for (int i = 0; i < 80; i++) mem_copy[FontBase + i] = GLYPHS[i];
            for (int i = 0; i < 16; i++) vregs[i] = 8'd0;
            for (int i = 0; i < 32; i++) frame_copy[i] = '0;
            index_copy = '0;
            pc_copy = 12'h200;
            start_pc_copy = 12'h200;
            mismatch_count = 0;
            expected_results.delete();
        end else begin
            // Register port: track writes, check read data.
            if (psel && penable && pready) begin
                if (pwrite) begin
                    start_pc_copy = pwdata[11:0];
                end else if (prdata !== {20'd0, start_pc_copy}) begin
                    $display("%t start_pc read: expected %h, actual %h",
                             $time, start_pc_copy, prdata);
                    mismatch_count++;
                end
            end
            // Result transfer: compare with the oldest expectation.
            if (m_tvalid && m_tready) begin
                got = m_tdata[78:0];
                if (expected_results.size() == 0) begin
                    $display("%t unexpected result: actual %h", $time, got);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.pc_now !== want.pc_now) begin
                        $display("%t pc_now: expected %h, actual %h",
                                 $time, want.pc_now, got.pc_now);
                        mismatch_count++;
                    end
                    if (got.row_pixels !== want.row_pixels) begin
                        $display("%t row_pixels: expected %h, actual %h",
                                 $time, want.row_pixels, got.row_pixels);
                        mismatch_count++;
                    end
                    if (got.collision !== want.collision) begin
                        $display("%t collision: expected %b, actual %b",
                                 $time, want.collision, got.collision);
                        mismatch_count++;
                    end
                    if (got.changed !== want.changed) begin
                        $display("%t display_changed: expected %b, actual %b",
                                 $time, want.changed, got.changed);
                        mismatch_count++;
                    end
                    if (got.unhandled !== want.unhandled) begin
                        $display("%t unhandled: expected %b, actual %b",
                                 $time, want.unhandled, got.unhandled);
                        mismatch_count++;
                    end
                end
            end
            // Request transfer: predict its result.
            if (s_tvalid && s_tready) begin
                execute_request(s_tuser, s_tdata, want);
                expected_results.push_back(want);
            end
        end
    end

endmodule

@@ sim/chip8_core_partial_execute_tb.sv @@
`timescale 1ns / 100ps
// ============================================================================
// chip8_core_partial_execute_tb
// Drives the interpreter core with short programs written into memory and
// stepped, frame row reads and noise requests, under random idling on both
// streams and one long output stall; a checker module judges every result.
// ============================================================================
module chip8_core_partial_execute_tb;
    import c8pe_pkg::*;

    localparam int WatchdogLimit = 20000;
    localparam int RandomItems = 1550;
    localparam logic [1:0] ReqIgnored = 2'd3;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [1:0]  s_tuser;   // req_type
    logic [31:0] s_tdata;   // address, data, row_index
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;   // pc_now, row_pixels, collision, changed, unhandled
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [0:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          mismatch_count;
    int          pending;
    int          cycle_count;
    int          item_count;
    logic [11:0] prog_pc;

    chip8_core_partial_execute dut (.*);

    chip8_core_partial_execute_chk checker_inst (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tuser, .s_tdata, .m_tvalid,
        .m_tready, .m_tdata, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
        .pready, .mismatch_count, .pending
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // Cycle count shared by the idling windows and the long output hold-off.
    always @(posedge aclk) cycle_count <= cycle_count + 1;

    // No idling on either side inside this window.
    function automatic logic steady_window();
        return cycle_count >= 12000 && cycle_count < 16000;
    endfunction

    // Receiver: random stalls, one long hold-off.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (cycle_count >= 8000 && cycle_count < 8400) begin
            m_tready <= 1'b0;
        end else if (steady_window()) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= 18);
        end
    end

    // Watchdog: too long without any transfer ends the run.
    always @(posedge aclk) begin
        int quiet;
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= WatchdogLimit) begin
                $display("** chip8_core_partial_execute: FAILED **");
                $finish;
            end
        end
    end

    // Offer one request and hold it until the transfer.
    task automatic put(input logic [1:0] kind, input logic [31:0] d);
        while (!steady_window() && $urandom_range(99) < 18) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= d;
        do @(posedge aclk); while (!s_tready);
        item_count++;
    endtask

    function automatic logic [31:0] pack_req(input logic [11:0] addr,
                                             input logic [7:0] data, input logic [4:0] row);
        return {7'd0, row, data, addr};
    endfunction

    // Write an opcode at the tracked pc, then step it.
    task automatic run_opcode(input logic [15:0] op);
        put(REQ_LOAD, pack_req(prog_pc, op[15:8], 5'($urandom)));
        put(REQ_LOAD, pack_req(12'(prog_pc + 1), op[7:0], 5'($urandom)));
        put(REQ_STEP, pack_req(12'($urandom), 8'($urandom), 5'($urandom)));
        if (op[15:12] == OP_JMP) prog_pc = op[11:0];
        else prog_pc = prog_pc + 12'd2;
    endtask

    task automatic apb_write(input logic [11:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 1'b0;
        pwdata <= {20'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        // Read back in the following transfer.
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Let all results drain, then a short pause before touching registers.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_opcode();
        int k;
        logic [3:0] groups [10] = '{4'h2, 4'h3, 4'h4, 4'h5, 4'h8, 4'h9, 4'hB, 4'hC,
                                    4'hE, 4'hF};
        k = $urandom_range(99);
        if (k < 22) return {OP_SETV, 12'($urandom)};
        if (k < 34) return {OP_ADDV, 12'($urandom)};
        if (k < 44) begin
            if ($urandom_range(4) == 0) return {OP_SETI, 12'hFF0 | 12'($urandom_range(15))};
            if ($urandom_range(3) == 0)
                return {OP_SETI, 12'(FontBase + 5 * $urandom_range(15))};
            return {OP_SETI, 12'($urandom)};
        end
        if (k < 72) return {OP_DRAW, 12'($urandom)};
        if (k < 75) return {OP_SYS, 8'($urandom), 4'h0};
        if (k < 78) return 16'h00EE;
        if (k < 81) return {OP_SYS, 8'($urandom), 4'($urandom_range(15, 1))};
        if (k < 88) begin
            if ($urandom_range(3) == 0) return {OP_JMP, 12'hFFF};
            return {OP_JMP, 12'($urandom)};
        end
        return {groups[$urandom_range(9)], 12'($urandom)};
    endfunction

    initial begin
        logic [11:0] settings [4] = '{12'h000, 12'hFFF, 12'h000, 12'h200};
        int r;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = '0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = 1'b0;
        pwdata = '0;
        item_count = 0;
        prog_pc = 12'h200;
        settings[2] = 12'($urandom);
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        apb_write(12'hFFF);

        // Directed: row extremes, ignored kind, wrapped draws, clear, jumps.
        put(REQ_ROW, pack_req(12'hFFF, 8'hFF, 5'd31));
        put(ReqIgnored, pack_req(12'hFFF, 8'hFF, 5'd31));
        run_opcode(16'h6F3E);   // VF used as the x coordinate, near the right edge
        run_opcode(16'h611E);   // y near the bottom edge
        run_opcode({OP_SETI, 12'hFFE});   // sprite rows run past the top of memory
        run_opcode(16'hDF13);
        run_opcode(16'hDF13);   // same sprite again, x now taken from the updated VF
        run_opcode(16'hD000);   // zero height
        put(REQ_ROW, pack_req(12'h000, 8'h00, 5'd0));
        run_opcode(16'h00E0);
        run_opcode(16'h00EE);
        run_opcode({OP_JMP, 12'hFFF});
        run_opcode(16'h71FF);   // fetch straddles the end of memory
        drain();
        apb_write(12'h000);

        // Random part in four phases with a register write after each.
        for (int phase = 0; phase < 4; phase++) begin
            while (item_count < 30 + (phase + 1) * RandomItems / 4) begin
                r = $urandom_range(99);
                if (r < 10) begin
                    put(REQ_LOAD, pack_req(12'($urandom), 8'($urandom), 5'($urandom)));
                end else if (r < 28) begin
                    put(REQ_ROW, pack_req(12'($urandom), 8'($urandom), 5'($urandom)));
                end else if (r < 31) begin
                    put(ReqIgnored, pack_req(12'($urandom), 8'($urandom), 5'($urandom)));
                end else begin
                    run_opcode(pick_opcode());
                end
            end
            drain();
            apb_write(settings[phase]);
        end

        repeat (100) @(posedge aclk);
        if (mismatch_count == 0 && pending == 0) begin
            $display("** chip8_core_partial_execute: PASSED **");
        end else begin
            $display("** chip8_core_partial_execute: FAILED **");
        end
        $finish;
    end

endmodule
